// File: rtl/pcrl_pkg.sv
// ----------------------------------------------------------------------------
// pcrl_pkg
// Types and constants shared by the packet class rate limiter.
// ----------------------------------------------------------------------------
package pcrl_pkg;

  localparam logic       CMD_WRITE       = 1'b0;
  localparam logic       CMD_CHECK       = 1'b1;

  localparam logic [1:0] CLASS_ANY       = 2'd0;
  localparam logic [1:0] CLASS_TCP       = 2'd1;
  localparam logic [1:0] CLASS_UDP       = 2'd2;

  localparam logic [7:0] PROTO_NUM_TCP   = 8'd6;
  localparam logic [7:0] PROTO_NUM_UDP   = 8'd17;

  localparam logic [15:0] WINDOW_RESET_MS = 16'd1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic        command;
    logic [2:0]  rule_index;
    logic        src_any;
    logic [31:0] src_ip;
    logic        dst_any;
    logic [31:0] dst_ip;
    logic [1:0]  rule_protocol;
    logic [7:0]  ip_protocol;
    logic [31:0] rule_rate;
    logic [15:0] pkt_length;
    logic [31:0] now_ms;
  } item_t;

  // cell sequencing controls
  typedef struct packed {
    logic match_en;
    logic commit;
  } cell_ctl_t;

  // priority result handed from cell to cell
  typedef struct packed {
    logic       found;
    logic       allowed;
    logic [2:0] hit_rule;
  } chain_t;

endpackage

// File: rtl/pcrl_ifs.sv
// ----------------------------------------------------------------------------
// pcrl_ifs
// Valid/ready channels of the rate limiter: item, result and configuration.
// ----------------------------------------------------------------------------
interface pcrl_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [2:0]  rule_index;
  logic        src_any;
  logic [31:0] src_ip;
  logic        dst_any;
  logic [31:0] dst_ip;
  logic [1:0]  rule_protocol;
  logic [7:0]  ip_protocol;
  logic [31:0] rule_rate;
  logic [15:0] pkt_length;
  logic [31:0] now_ms;

  modport source (output valid, command, rule_index, src_any, src_ip, dst_any, dst_ip,
                  rule_protocol, ip_protocol, rule_rate, pkt_length, now_ms,
                  input ready);
  modport sink (input valid, command, rule_index, src_any, src_ip, dst_any, dst_ip,
                rule_protocol, ip_protocol, rule_rate, pkt_length, now_ms,
                output ready);
endinterface

interface pcrl_result_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic       matched;
  logic [2:0] hit_rule;

  modport source (output valid, allowed, matched, hit_rule, input ready);
  modport sink (input valid, allowed, matched, hit_rule, output ready);
endinterface

interface pcrl_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/packet_class_rate_limiter.sv
// ----------------------------------------------------------------------------
// packet_class_rate_limiter
// Per-rule fixed window byte limiter over a row of rule cells.
// ----------------------------------------------------------------------------
// Steps: the match step compares all cells and checks window expiry; the
//   decide step resolves first match along the cell chain, updates the
//   chosen cell's counter or writes the rule, and registers the result.
//   A stalled result holds the decide step; a new item is taken as it commits.
// Reset: all rules invalid, window_ms = 1000, no result pending.
module packet_class_rate_limiter #(
  parameter int NUM_RULES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  pcrl_item_if.sink            item,
  pcrl_result_if.source        result,
  pcrl_cfg_if.sink             cfg
);

  pcrl_pkg::state_t    state;
  pcrl_pkg::state_t    state_next;
  pcrl_pkg::item_t     item_q;
  pcrl_pkg::cell_ctl_t ctl;
  pcrl_pkg::chain_t    chain [NUM_RULES+1];

  logic [15:0] window_ms;
  logic        out_valid;
  logic        out_allowed;
  logic        out_matched;
  logic [2:0]  out_hit_rule;
  logic        out_free;
  logic        commit;
  logic        accept;

  assign out_free  = !out_valid || result.ready;
  assign commit    = (state == pcrl_pkg::ST_DECIDE) && out_free;
  assign item.ready = (state == pcrl_pkg::ST_IDLE) || commit;
  assign accept    = item.valid && item.ready;
  assign cfg.ready = 1'b1;

  assign ctl.match_en = (state == pcrl_pkg::ST_MATCH);
  assign ctl.commit   = commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcrl_pkg::ST_IDLE:   if (accept) state_next = pcrl_pkg::ST_MATCH;
      pcrl_pkg::ST_MATCH:  state_next = pcrl_pkg::ST_DECIDE;
      pcrl_pkg::ST_DECIDE: begin
        if (commit) state_next = accept ? pcrl_pkg::ST_MATCH : pcrl_pkg::ST_IDLE;
      end
      default:             state_next = pcrl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.command       <= item.command;
      item_q.rule_index    <= item.rule_index;
      item_q.src_any       <= item.src_any;
      item_q.src_ip        <= item.src_ip;
      item_q.dst_any       <= item.dst_any;
      item_q.dst_ip        <= item.dst_ip;
      item_q.rule_protocol <= item.rule_protocol;
      item_q.ip_protocol   <= item.ip_protocol;
      item_q.rule_rate     <= item.rule_rate;
      item_q.pkt_length    <= item.pkt_length;
      item_q.now_ms        <= item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= pcrl_pkg::WINDOW_RESET_MS;
    end else if (cfg.valid && cfg.ready) begin
      window_ms <= cfg.data;
    end
  end

  assign chain[0] = '0;

  for (genvar k = 0; k < NUM_RULES; k++) begin : g_cell
    pcrl_cell #(.IDX(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .item      (item_q),
      .window_ms (window_ms),
      .ctl       (ctl),
      .chain_in  (chain[k]),
      .chain_out (chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (item_q.command == pcrl_pkg::CMD_WRITE) begin
        out_allowed  <= 1'b0;
        out_matched  <= 1'b0;
        out_hit_rule <= '0;
      end else if (chain[NUM_RULES].found) begin
        out_allowed  <= chain[NUM_RULES].allowed;
        out_matched  <= 1'b1;
        out_hit_rule <= chain[NUM_RULES].hit_rule;
      end else begin
        // no rule claims the packet: pass it
        out_allowed  <= 1'b1;
        out_matched  <= 1'b0;
        out_hit_rule <= '0;
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.allowed  = out_allowed;
  assign result.matched  = out_matched;
  assign result.hit_rule = out_hit_rule;

  a_match_then_decide: assert property (@(posedge clk) disable iff (rst)
    state == pcrl_pkg::ST_MATCH |=> state == pcrl_pkg::ST_DECIDE)
    else $error("match step not followed by decide step");

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == pcrl_pkg::ST_DECIDE)
    else $error("result loaded outside decide step");

  a_nomatch_index: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.matched |-> result.hit_rule == 3'd0)
    else $error("rule index reported without a match");

endmodule

// File: rtl/pcrl_cell.sv
// ----------------------------------------------------------------------------
// pcrl_cell
// One rule slot: rule storage, window counter and first-match chain link.
// ----------------------------------------------------------------------------
module pcrl_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  pcrl_pkg::item_t     item,
  input  logic [15:0]         window_ms,
  input  pcrl_pkg::cell_ctl_t ctl,
  input  pcrl_pkg::chain_t    chain_in,
  output pcrl_pkg::chain_t    chain_out
);

  logic        valid;
  logic        src_wild;
  logic [31:0] src_addr;
  logic        dst_wild;
  logic [31:0] dst_addr;
  logic [1:0]  proto_class;
  logic [31:0] rate;
  logic [31:0] bytes;
  logic [31:0] start;
  logic        hit;
  logic        expired;

  logic        src_ok;
  logic        dst_ok;
  logic        proto_ok;
  logic [31:0] base;
  logic [32:0] sum;
  logic        fits;
  logic        sel;
  logic        wr_sel;

  always_comb begin
    src_ok = src_wild || (src_addr == item.src_ip);
    dst_ok = dst_wild || (dst_addr == item.dst_ip);
    case (proto_class)
      pcrl_pkg::CLASS_TCP: proto_ok = (item.ip_protocol == pcrl_pkg::PROTO_NUM_TCP);
      pcrl_pkg::CLASS_UDP: proto_ok = (item.ip_protocol == pcrl_pkg::PROTO_NUM_UDP);
      default:             proto_ok = 1'b1;
    endcase
    // expired window counts from zero
    base   = expired ? '0 : bytes;
    sum    = {1'b0, base} + 33'(item.pkt_length);
    fits   = (sum <= {1'b0, rate});
    sel    = hit && !chain_in.found;
    wr_sel = (item.command == pcrl_pkg::CMD_WRITE) && (32'(item.rule_index) == 32'(IDX));
    chain_out = chain_in;
    if (sel) begin
      chain_out.found    = 1'b1;
      chain_out.allowed  = fits;
      chain_out.hit_rule = 3'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.commit && wr_sel) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.match_en) begin
      hit     <= valid && src_ok && dst_ok && proto_ok &&
                 (item.command == pcrl_pkg::CMD_CHECK);
      expired <= (item.now_ms - start) > 32'(window_ms);
    end
    if (ctl.commit) begin
      if (wr_sel) begin
        src_wild    <= item.src_any;
        src_addr    <= item.src_ip;
        dst_wild    <= item.dst_any;
        dst_addr    <= item.dst_ip;
        proto_class <= item.rule_protocol;
        rate        <= item.rule_rate;
        bytes       <= '0;
        start       <= '0;
      end else if (sel) begin
        if (expired) begin
          start <= item.now_ms;
        end
        bytes <= fits ? sum[31:0] : base;
      end
    end
  end

endmodule
